FILE: rtl/core/bsc_pkg.sv
// Shared types, constants and the calibration unpacking for the barometer compensation block.
`timescale 1ns / 1ps

package bsc_pkg;

	// Raw conversion code that marks a failed reading.
	localparam logic [15:0] RawFail = 16'hFFFF;

	// Fixed offsets of the compensation formulas.
	localparam int Ut1Base   = 20224;
	localparam int D1Offset  = 7168;
	localparam int SensBase  = 24576;
	localparam int C4Bias    = 512;
	localparam int SlopeWarm = 50;
	localparam int SlopeCold = 54;
	localparam int TempBase  = 200;
	localparam int PresBase  = 2500;

	// Output ranges.
	localparam int TempMin = -8192;
	localparam int TempMax = 8191;
	localparam int PresMin = -262144;
	localparam int PresMax = 262143;

	// Number of register stages from request acceptance to the output register.
	localparam int StageCount = 9;

	typedef struct packed {
		logic [14:0] c1;
		logic [10:0] c5;
		logic [5:0]  c6;
		logic [9:0]  c4;
		logic [9:0]  c3;
		logic [11:0] c2;
	} coef_t;

	// Corrected temperature difference and pressure offset after the front stages.
	typedef struct packed {
		logic               ok;
		logic signed [17:0] dt;
		logic signed [16:0] d1off;
	} front_t;

	// Temperature, offset and sensitivity after the slope stages.
	typedef struct packed {
		logic               ok;
		logic signed [15:0] temp;
		logic signed [17:0] off;
		logic signed [18:0] sens;
		logic signed [16:0] d1off;
	} slope_t;

	function automatic coef_t unpack_calib(input logic [63:0] w);
		coef_t c;
		c.c1 = w[63:49];
		c.c5 = w[48:38];
		c.c6 = w[37:32];
		c.c4 = w[31:22];
		c.c3 = w[15:6];
		c.c2 = {w[21:16], w[5:0]};
		return c;
	endfunction

endpackage

FILE: rtl/core/bsc_in_if.sv
// Request channel carrying one raw pressure and temperature pair.
`timescale 1ns / 1ps

interface bsc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_pressure;
	logic [15:0] raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

FILE: rtl/core/bsc_out_if.sv
// Result channel carrying the compensated temperature and pressure.
`timescale 1ns / 1ps

interface bsc_out_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic signed [13:0] temperature_tenths;
	logic signed [18:0] pressure_tenths;

	modport source (output valid, output valid_res, output temperature_tenths,
		output pressure_tenths, input ready);
	modport sink (input valid, input valid_res, input temperature_tenths,
		input pressure_tenths, output ready);
endinterface

FILE: rtl/core/bsc_front.sv
// Stages one to three: temperature difference, its square and the cold-side correction.
`timescale 1ns / 1ps

module bsc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  bsc_pkg::coef_t    coef,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       raw_pressure,
	input  logic [15:0]       raw_temperature,
	output logic              out_valid,
	input  logic              out_ready,
	output bsc_pkg::front_t   out_data
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic               ok_s1, ok_s2, ok_s3;
	logic signed [17:0] dt_s1, dt_s2, dtc_s3;
	logic signed [16:0] d1off_s1, d1off_s2, d1off_s3;
	logic [14:0]        corr_s2;

	logic [15:0]        ut1;
	logic signed [17:0] dt_c;
	logic signed [16:0] d1off_c;
	logic               ok_c;
	logic signed [35:0] sq_c;
	logic [14:0]        corr_c;
	logic signed [17:0] dtc_c;

	// A stage takes new data when it is empty or its successor moves on.
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign ut1     = {2'b00, coef.c5, 3'b000} + 16'(bsc_pkg::Ut1Base);
	assign dt_c    = $signed({2'b00, raw_temperature}) - $signed({2'b00, ut1});
	assign d1off_c = $signed({1'b0, raw_pressure}) - $signed(17'(bsc_pkg::D1Offset));
	assign ok_c    = (raw_pressure != bsc_pkg::RawFail) && (raw_temperature != bsc_pkg::RawFail);

	// The square is below 2^31 whenever dT is negative, the only case that uses it.
	assign sq_c   = dt_s1 * dt_s1;
	assign corr_c = dt_s1[17] ? sq_c[30:16] : 15'd0;

	assign dtc_c = dt_s2 - $signed({3'b000, corr_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ok_s1    <= ok_c;
			dt_s1    <= dt_c;
			d1off_s1 <= d1off_c;
		end
		if (en_s2) begin
			ok_s2    <= ok_s1;
			dt_s2    <= dt_s1;
			d1off_s2 <= d1off_s1;
			corr_s2  <= corr_c;
		end
		if (en_s3) begin
			ok_s3    <= ok_s2;
			dtc_s3   <= dtc_c;
			d1off_s3 <= d1off_s2;
		end
	end

	assign out_valid      = v_s3;
	assign out_data.ok    = ok_s3;
	assign out_data.dt    = dtc_s3;
	assign out_data.d1off = d1off_s3;

endmodule

FILE: rtl/core/bsc_slope.sv
// Stages four and five: slope products, temperature, offset and sensitivity.
`timescale 1ns / 1ps

module bsc_slope (
	input  logic              clk,
	input  logic              arst_n,
	input  bsc_pkg::coef_t    coef,
	input  logic              in_valid,
	output logic              in_ready,
	input  bsc_pkg::front_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bsc_pkg::slope_t   out_data
);

	logic v_s4, v_s5;
	logic en_s4, en_s5;

	logic               ok_s4;
	logic signed [16:0] d1off_s4;
	logic signed [25:0] tprod_s4;
	logic signed [28:0] oprod_s4;
	logic signed [28:0] sprod_s4;

	logic signed [17:0] dt;
	logic [6:0]         slope;
	logic signed [10:0] c4b;
	logic signed [25:0] tprod_c;
	logic signed [28:0] oprod_c;
	logic signed [28:0] sprod_c;
	logic signed [15:0] temp_c;
	logic signed [17:0] off_c;
	logic signed [18:0] sens_c;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	assign dt    = $signed(in_data.dt);
	// The colder side uses the steeper temperature slope.
	assign slope = {1'b0, coef.c6} +
		(dt[17] ? 7'(bsc_pkg::SlopeCold) : 7'(bsc_pkg::SlopeWarm));
	assign c4b   = $signed({1'b0, coef.c4}) - $signed(11'(bsc_pkg::C4Bias));

	assign tprod_c = dt * $signed({1'b0, slope});
	assign oprod_c = dt * c4b;
	assign sprod_c = dt * $signed({1'b0, coef.c3});

	// Part-selects of the products are the floor shifts.
	assign temp_c = $signed(16'(bsc_pkg::TempBase)) + $signed(tprod_s4[25:10]);
	assign off_c  = $signed({4'b0000, coef.c2, 2'b00}) +
		$signed({oprod_s4[28], oprod_s4[28:12]});
	assign sens_c = $signed({4'b0000, coef.c1}) + $signed(sprod_s4[28:10]) +
		$signed(19'(bsc_pkg::SensBase));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ok_s4    <= in_data.ok;
			d1off_s4 <= in_data.d1off;
			tprod_s4 <= tprod_c;
			oprod_s4 <= oprod_c;
			sprod_s4 <= sprod_c;
		end
		if (en_s5) begin
			out_data.ok    <= ok_s4;
			out_data.temp  <= temp_c;
			out_data.off   <= off_c;
			out_data.sens  <= sens_c;
			out_data.d1off <= d1off_s4;
		end
	end

	assign out_valid = v_s5;

endmodule

FILE: rtl/core/bsc_press.sv
// Stages six to nine: pressure product, offset removal, scaling and output saturation.
`timescale 1ns / 1ps

module bsc_press (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bsc_pkg::slope_t    in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               valid_res,
	output logic signed [13:0] temperature_tenths,
	output logic signed [18:0] pressure_tenths
);

	logic v_s6, v_s7, v_s8, v_s9;
	logic en_s6, en_s7, en_s8, en_s9;

	logic               ok_s6, ok_s7, ok_s8;
	logic signed [15:0] temp_s6, temp_s7, temp_s8;
	logic signed [17:0] off_s6;
	logic signed [35:0] prod_s6;
	logic signed [22:0] x_s7;
	logic signed [26:0] p10_s8;

	logic signed [35:0] prod_c;
	logic signed [22:0] x_c;
	logic signed [26:0] p10_c;
	logic signed [21:0] p_c;
	logic signed [18:0] p_sat;
	logic signed [13:0] t_sat;

	assign en_s9    = !v_s9 || out_ready;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	assign prod_c = $signed(in_data.sens) * $signed(in_data.d1off);
	assign x_c    = $signed({prod_s6[35], prod_s6[35:14]}) - $signed({{5{off_s6[17]}}, off_s6});
	// Ten times X as eight times plus two times.
	assign p10_c  = $signed({x_s7[22], x_s7, 3'b000}) + $signed({{3{x_s7[22]}}, x_s7, 1'b0});
	assign p_c    = $signed(22'(bsc_pkg::PresBase)) + $signed(p10_s8[26:5]);

	always_comb begin
		if (p_c < $signed(22'(bsc_pkg::PresMin))) begin
			p_sat = 19'(bsc_pkg::PresMin);
		end else if (p_c > $signed(22'(bsc_pkg::PresMax))) begin
			p_sat = 19'(bsc_pkg::PresMax);
		end else begin
			p_sat = p_c[18:0];
		end
		if (temp_s8 < $signed(16'(bsc_pkg::TempMin))) begin
			t_sat = 14'(bsc_pkg::TempMin);
		end else if (temp_s8 > $signed(16'(bsc_pkg::TempMax))) begin
			t_sat = 14'(bsc_pkg::TempMax);
		end else begin
			t_sat = temp_s8[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= in_valid;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			ok_s6   <= in_data.ok;
			temp_s6 <= in_data.temp;
			off_s6  <= in_data.off;
			prod_s6 <= prod_c;
		end
		if (en_s7) begin
			ok_s7   <= ok_s6;
			temp_s7 <= temp_s6;
			x_s7    <= x_c;
		end
		if (en_s8) begin
			ok_s8   <= ok_s7;
			temp_s8 <= temp_s7;
			p10_s8  <= p10_c;
		end
		if (en_s9) begin
			// A failed reading reports zeros in both result fields.
			valid_res          <= ok_s8;
			temperature_tenths <= ok_s8 ? t_sat : 14'sd0;
			pressure_tenths    <= ok_s8 ? p_sat : 19'sd0;
		end
	end

	assign out_valid = v_s9;

endmodule

FILE: rtl/core/baro_sensor_compensation.sv
// Top level of the barometric sensor compensation pipeline.
`timescale 1ns / 1ps

// Each request carries one raw pressure word and one raw temperature word and yields exactly
// one result with the compensated temperature in 0.1 degC and pressure in 0.1 hPa, saturated
// to the output widths; a raw word of all ones gives valid_res low and zero fields. The block
// accepts one request in every clock cycle while the result side does not stall. The datapath
// holds nine register stages, and the first of them captures the request at the accepting edge.
// The stages are needed because several multiplies follow one another: the square of the
// temperature difference, then the three slope multiplies that use the corrected difference,
// then the sensitivity times pressure multiply that needs their result. When the result side
// stalls, requests are still accepted until every stage holds an item, and nothing is dropped
// or repeated. The 64-bit calibration word is written through cfg_wr_en and cfg_wr_data; it
// resets to zero and must only be changed while no request is in flight.

module baro_sensor_compensation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [63:0]  cfg_wr_data,
	bsc_in_if.sink       sample,
	bsc_out_if.source    result
);

	logic [63:0]      calib_q;
	bsc_pkg::coef_t   coef;

	logic             front_valid, front_ready;
	bsc_pkg::front_t  front_data;
	logic             slope_valid, slope_ready;
	bsc_pkg::slope_t  slope_data;

	// The calibration word is held as written and unpacked into its six coefficients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= 64'd0;
		end else if (cfg_wr_en) begin
			calib_q <= cfg_wr_data;
		end
	end

	assign coef = bsc_pkg::unpack_calib(calib_q);

	// Temperature difference and its second-order correction below the reference point.
	bsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coef            (coef),
		.in_valid        (sample.valid),
		.in_ready        (sample.ready),
		.raw_pressure    (sample.raw_pressure),
		.raw_temperature (sample.raw_temperature),
		.out_valid       (front_valid),
		.out_ready       (front_ready),
		.out_data        (front_data)
	);

	// Temperature result, pressure offset and sensitivity from the corrected difference.
	bsc_slope u_slope (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (slope_valid),
		.out_ready (slope_ready),
		.out_data  (slope_data)
	);

	// Pressure computation and the output register facing the result channel.
	bsc_press u_press (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (slope_valid),
		.in_ready           (slope_ready),
		.in_data            (slope_data),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.valid_res          (result.valid_res),
		.temperature_tenths (result.temperature_tenths),
		.pressure_tenths    (result.pressure_tenths)
	);

endmodule

FILE: rtl/core/bsc_checker.sv
// Port-level assertions for the compensation pipeline and their bind to the top level.
`timescale 1ns / 1ps

module bsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        valid_res,
	input logic [13:0] temperature_tenths,
	input logic [18:0] pressure_tenths
);

	localparam int CntW = $clog2(bsc_pkg::StageCount + 1);

	logic [CntW-1:0] cnt_q;
	logic            in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Requests accepted whose results have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CntW'(in_acc) - CntW'(out_acc);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({valid_res, temperature_tenths, pressure_tenths}))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> temperature_tenths == 14'd0 && pressure_tenths == 19'd0)
		else $error("failed reading with nonzero fields");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result without a pending request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(bsc_pkg::StageCount))
		else $error("more requests in flight than pipeline stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> in_ready)
		else $error("empty pipeline refuses a request");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (sample.valid),
	.in_ready           (sample.ready),
	.out_valid          (result.valid),
	.out_ready          (result.ready),
	.valid_res          (result.valid_res),
	.temperature_tenths (result.temperature_tenths),
	.pressure_tenths    (result.pressure_tenths)
);
